[src/prime_test_and_search_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the prime test and search block
// Shared concurrent assertion forms, clocked on i_clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PRIME_TEST_AND_SEARCH_TOP_ASSERT_SVH
`define PRIME_TEST_AND_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define PTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define PTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Types and constants shared by the prime test and search modules.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int VALUE_WIDTH_DEF = 31;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_TEST = 2'd0,
        OP_NEXT = 2'd1,
        OP_PREV = 2'd2
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request value as candidate
        logic step_up;    // candidate + 1
        logic step_down;  // candidate - 1
        logic init_div;   // divisor = 2, square = 4
        logic mod_start;  // begin a remainder computation
        logic mod_step;   // one remainder bit
        logic next_div;   // divisor + 1, square updated
        logic finish;     // register the result
        logic res_prime;
        logic res_found;
        logic res_zero;   // answer forced to zero
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lt_two;     // candidate below two
        logic le_two;     // candidate at most two
        logic at_top;     // candidate is the largest value
        logic sq_gt;      // divisor squared exceeds candidate
        logic mod_last;   // last remainder bit in progress
        logic rem_zero;   // remainder is zero
    } t_dp_status;

endpackage

[src/pts_dp.sv]
// ----------------------------------------------------------------------------
// pts_dp
// Datapath: candidate, trial divisor with running square, bit-serial
// remainder unit and result registers.
// ----------------------------------------------------------------------------
module pts_dp
    import pts_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic [VALUE_WIDTH-1:0] o_answer,
    output logic                   o_is_prime,
    output logic                   o_found
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [W-1:0]     r_cand, n_cand;
    logic [W-1:0]     r_div, n_div;
    logic [W+1:0]     r_sq, n_sq;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_shift, n_shift;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W:0]       rem_sh;

    always_comb begin
        n_cand  = r_cand;
        n_div   = r_div;
        n_sq    = r_sq;
        n_rem   = r_rem;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        rem_sh  = {r_rem, r_shift[W-1]};

        if (i_cmd.load) begin
            n_cand = i_value;
        end else if (i_cmd.step_up) begin
            n_cand = r_cand + W'(1);
        end else if (i_cmd.step_down) begin
            n_cand = r_cand - W'(1);
        end

        if (i_cmd.init_div) begin
            n_div = W'(2);
            n_sq  = (W + 2)'(4);
        end else if (i_cmd.next_div) begin
            // (d + 1)^2 = d^2 + 2d + 1
            n_div = r_div + W'(1);
            n_sq  = r_sq + {1'b0, r_div, 1'b1};
        end

        if (i_cmd.mod_start) begin
            n_rem   = '0;
            n_shift = r_cand;
            n_cnt   = CNT_W'(W);
        end else if (i_cmd.mod_step) begin
            // Restoring remainder, one dividend bit per cycle, MSB first.
            if (rem_sh >= {1'b0, r_div}) begin
                n_rem = W'(rem_sh - {1'b0, r_div});
            end else begin
                n_rem = W'(rem_sh);
            end
            n_shift = {r_shift[W-2:0], 1'b0};
            n_cnt   = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_div   <= n_div;
        r_sq    <= n_sq;
        r_rem   <= n_rem;
        r_shift <= n_shift;
        r_cnt   <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_answer   <= '0;
            o_is_prime <= 1'b0;
            o_found    <= 1'b0;
        end else if (i_cmd.finish) begin
            o_answer   <= i_cmd.res_zero ? '0 : r_cand;
            o_is_prime <= i_cmd.res_prime;
            o_found    <= i_cmd.res_found;
        end
    end

    assign o_status.lt_two   = (r_cand < W'(2));
    assign o_status.le_two   = (r_cand <= W'(2));
    assign o_status.at_top   = (r_cand == {W{1'b1}});
    assign o_status.sq_gt    = (r_sq > {2'b00, r_cand});
    assign o_status.mod_last = (r_cnt == CNT_W'(1));
    assign o_status.rem_zero = (r_rem == '0);

    `include "prime_test_and_search_top_assert.svh"

    `PTS_ASSERT_IMP(a_found_is_prime, o_found, o_is_prime)
    `PTS_ASSERT_IMP(a_div_at_least_two, i_cmd.mod_step, r_div >= W'(2))

endmodule

[src/pts_ctrl.sv]
// ----------------------------------------------------------------------------
// pts_ctrl
// Controller: sequences candidate stepping, trial division and the result.
// ----------------------------------------------------------------------------
module pts_ctrl
    import pts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_operation,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy,
    output logic       o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CHECK,
        S_MOD,
        S_EVAL
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_op, n_op;
    logic       r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_valid = 1'b0;
        o_cmd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_operation;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (r_op)
                    OP_TEST: begin
                        o_cmd.init_div = 1'b1;
                        n_state        = S_CHECK;
                    end
                    OP_NEXT: begin
                        if (i_status.at_top) begin
                            o_cmd.finish   = 1'b1;
                            o_cmd.res_zero = 1'b1;
                            n_valid        = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.step_up  = 1'b1;
                            o_cmd.init_div = 1'b1;
                            n_state        = S_CHECK;
                        end
                    end
                    OP_PREV: begin
                        if (i_status.le_two) begin
                            o_cmd.finish   = 1'b1;
                            o_cmd.res_zero = 1'b1;
                            n_valid        = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.step_down = 1'b1;
                            o_cmd.init_div  = 1'b1;
                            n_state         = S_CHECK;
                        end
                    end
                    default: begin
                        o_cmd.finish   = 1'b1;
                        o_cmd.res_zero = 1'b1;
                        n_valid        = 1'b1;
                        n_state        = S_IDLE;
                    end
                endcase
            end
            S_CHECK: begin
                if (i_status.lt_two) begin
                    // Below two is never prime; a search moves on.
                    if (r_op == OP_TEST) begin
                        o_cmd.finish = 1'b1;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_DISPATCH;
                    end
                end else if (i_status.sq_gt) begin
                    o_cmd.finish    = 1'b1;
                    o_cmd.res_prime = 1'b1;
                    o_cmd.res_found = (r_op != OP_TEST);
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.rem_zero) begin
                    if (r_op == OP_TEST) begin
                        o_cmd.finish = 1'b1;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_DISPATCH;
                    end
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_TEST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    `include "prime_test_and_search_top_assert.svh"

    `PTS_ASSERT_NXT(a_start_takes, start && !busy, busy)
    `PTS_ASSERT_NXT(a_strobe_single, o_valid, !o_valid)
    `PTS_ASSERT_IMP(a_strobe_idle, o_valid, !busy)
    `PTS_ASSERT_IMP(a_one_dp_move, o_cmd.step_up, !o_cmd.step_down && !o_cmd.load)

endmodule

[src/prime_test_and_search_top.sv]
// ----------------------------------------------------------------------------
// prime_test_and_search_top
// Primality test and next/previous prime search by trial division.
// ----------------------------------------------------------------------------
// A test of n divides it by each trial divisor in turn, using the bit-serial
//   remainder unit, which works through the candidate one bit at a time.
// A search repeats that test over each candidate until a prime or the range end.
// Throughput: one request at a time; the next start is taken when busy is low.
// Reset (i_rst_n, synchronous, active low) returns the block to idle, clears
//   the result strobe and the result fields. The receiver cannot stall.

module prime_test_and_search_top
    import pts_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_operation,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_answer,
    output logic                   o_is_prime,
    output logic                   o_found
);

    // The controller steps through candidates and divisors; the datapath
    // holds the numbers. Each request produces exactly one result transfer,
    // marked by o_valid for one cycle, in the same cycle busy falls.

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .busy        (busy),
        .o_valid     (o_valid)
    );

    // Trial divisors run from two while d*d <= candidate; the square is kept
    // incrementally so no multiplier is needed.
    pts_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_value),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_answer   (o_answer),
        .o_is_prime (o_is_prime),
        .o_found    (o_found)
    );

endmodule
